### hw/rtl/mssc_pkg.sv
package mssc_pkg;

    // counter width default and register reset values
    localparam int          COUNT_BITS_DEF = 32;
    localparam logic [31:0] WINDOW_RESET   = 32'd262144;
    localparam int          ADDR_BITS      = 3;

    // received frame flag positions
    localparam int FLAG_SYN = 0;
    localparam int FLAG_ACK = 1;
    localparam int FLAG_FIN = 2;
    localparam int FLAG_RST = 3;

    // register byte address
    localparam logic [ADDR_BITS-1:0] ADDR_WINDOW = 3'd0;

    typedef enum logic [2:0] {
        OP_RX_DATA        = 3'd0,
        OP_RX_WINDOW      = 3'd1,
        OP_APP_READ       = 3'd2,
        OP_APP_WRITE      = 3'd3,
        OP_CLOSE          = 3'd4,
        OP_RESET          = 3'd5,
        OP_SESSION_CLOSED = 3'd6,
        OP_OPEN_SENT      = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        LC_INIT         = 3'd0,
        LC_SYN_SENT     = 3'd1,
        LC_SYN_RECV     = 3'd2,
        LC_ESTABLISHED  = 3'd3,
        LC_LOCAL_CLOSE  = 3'd4,
        LC_REMOTE_CLOSE = 3'd5,
        LC_CLOSED       = 3'd6,
        LC_RESET        = 3'd7
    } lc_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RESET    = 3'd1,
        ST_SHUTDOWN = 3'd2,
        ST_CLOSED   = 3'd3,
        ST_WINDOW   = 3'd4,
        ST_EOF      = 3'd5,
        ST_BLOCK    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        EM_NONE = 3'd0,
        EM_DATA = 3'd1,
        EM_FIN  = 3'd2,
        EM_WU   = 3'd3,
        EM_RST  = 3'd4
    } emit_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] length;
        logic [3:0]  flags;
    } item_t;

    typedef struct packed {
        status_t     status;
        lc_t         state;
        logic [31:0] byte_count;
        emit_t       emit;
        logic [31:0] amount;
        logic        ack_pending;
        logic        remote_finished;
    } result_t;

endpackage

### hw/rtl/mssc_cfg.sv
module mssc_cfg
    import mssc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output logic [31:0]          credit_window
);

    logic [31:0] window_reg;
    logic        wr_en;

    // write strobe on the access cycle
    assign wr_en = psel && penable && pwrite && (paddr == ADDR_WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (wr_en)
        begin
            window_reg <= pwdata;
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_WINDOW)
        begin
            prdata = window_reg;
        end
    end

    assign pready        = 1'b1;
    assign credit_window = window_reg;

endmodule

### hw/rtl/mssc_in_stage.sv
module mssc_in_stage
    import mssc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [31:0] length,
    input  logic [3:0]  frame_flags,
    output logic        item_valid,
    output item_t       item,
    input  logic        item_ready
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // accept a new request when none is held or the held one leaves this cycle
    assign in_ready = !valid_reg || item_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op     <= op_t'(op);
            item_reg.length <= length;
            item_reg.flags  <= frame_flags;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hw/rtl/mssc_core.sv
module mssc_core
    import mssc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] credit_window,
    input  logic        item_valid,
    input  item_t       item,
    output logic        item_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     result
);

    localparam int              CW       = COUNT_BITS;
    localparam logic [32:0]     CMAX33   = (33'd1 << CW) - 33'd1;
    localparam logic [CW-1:0]   CMAX     = CMAX33[CW-1:0];
    localparam logic [CW-1:0]   CREDIT_RESET =
        ({1'b0, WINDOW_RESET} > CMAX33) ? CMAX33[CW-1:0] : WINDOW_RESET[CW-1:0];

    // stream state
    lc_t           lc_reg, lc_next;
    logic [CW-1:0] send_reg, send_next;
    logic [CW-1:0] recv_reg, recv_next;
    logic [CW-1:0] queued_reg, queued_next;
    logic [CW-1:0] consumed_reg, consumed_next;
    logic          lfin_reg, lfin_next;
    logic          rfin_reg, rfin_next;
    logic          rst_seen_reg, rst_seen_next;
    logic          down_reg, down_next;
    logic          ack_reg, ack_next;

    // result register
    logic          out_valid_reg;
    result_t       result_reg, result_next;
    logic          advance;

    // datapath terms
    lc_t           lc_open;
    logic          ack_open;
    logic [32:0]   len33;
    logic [CW-1:0] len_cw;
    logic [CW-1:0] len_sat;
    logic          rx_over;
    logic [CW:0]   q_sum;
    logic [CW-1:0] q_sat;
    logic [CW:0]   s_sum;
    logic [CW-1:0] s_sat;
    logic [CW-1:0] rd_bytes;
    logic [CW:0]   c_sum;
    logic [CW-1:0] c_sat;
    logic          win_hit;
    logic [CW:0]   r_sum;
    logic [CW-1:0] r_sat;
    logic [CW-1:0] wr_bytes;

    // lifecycle after a received FIN
    function automatic lc_t fin_lc(lc_t lc);
        lc_t nxt;
        nxt = lc;
        case (lc)
            LC_ESTABLISHED, LC_SYN_RECV: nxt = LC_REMOTE_CLOSE;
            LC_LOCAL_CLOSE:              nxt = LC_CLOSED;
            default:                     nxt = lc;
        endcase
        return nxt;
    endfunction

    assign item_ready = !out_valid_reg || out_ready;
    assign advance    = item_valid && item_ready;

    // shared arithmetic terms
    always_comb
    begin
        // SYN and ACK handling common to both received frame kinds
        lc_open  = lc_reg;
        ack_open = ack_reg;
        if (item.flags[FLAG_SYN] && (lc_reg == LC_INIT))
        begin
            lc_open  = LC_SYN_RECV;
            ack_open = 1'b1;
        end
        if (item.flags[FLAG_ACK] && ((lc_open == LC_SYN_SENT) || (lc_open == LC_SYN_RECV)))
        begin
            lc_open = LC_ESTABLISHED;
        end

        len33   = {1'b0, item.length};
        len_cw  = item.length[CW-1:0];
        len_sat = (len33 > CMAX33) ? CMAX : len_cw;
        rx_over = len33 > 33'(recv_reg);

        // saturating queue and send credit adds
        q_sum = {1'b0, queued_reg} + {1'b0, len_cw};
        q_sat = q_sum[CW] ? CMAX : q_sum[CW-1:0];
        s_sum = {1'b0, send_reg} + {1'b0, len_sat};
        s_sat = s_sum[CW] ? CMAX : s_sum[CW-1:0];

        // read take and credit return
        rd_bytes = (len33 < 33'(queued_reg)) ? len_cw : queued_reg;
        c_sum    = {1'b0, consumed_reg} + {1'b0, rd_bytes};
        c_sat    = c_sum[CW] ? CMAX : c_sum[CW-1:0];
        win_hit  = 32'(c_sat) >= (credit_window >> 1);
        r_sum    = {1'b0, recv_reg} + {1'b0, c_sat};
        r_sat    = r_sum[CW] ? CMAX : r_sum[CW-1:0];

        // write grant
        wr_bytes = (len33 < 33'(send_reg)) ? len_cw : send_reg;
    end

    // per-request decode
    always_comb
    begin
        lc_next       = lc_reg;
        send_next     = send_reg;
        recv_next     = recv_reg;
        queued_next   = queued_reg;
        consumed_next = consumed_reg;
        lfin_next     = lfin_reg;
        rfin_next     = rfin_reg;
        rst_seen_next = rst_seen_reg;
        down_next     = down_reg;
        ack_next      = ack_reg;

        result_next.status     = ST_OK;
        result_next.byte_count = '0;
        result_next.emit       = EM_NONE;
        result_next.amount     = '0;

        unique case (item.op)
            OP_RX_DATA:
            begin
                lc_next  = lc_open;
                ack_next = ack_open;
                if ((item.length != 32'd0) && rx_over)
                begin
                    result_next.status = ST_WINDOW;
                end
                else
                begin
                    if (item.length != 32'd0)
                    begin
                        recv_next   = recv_reg - len_cw;
                        queued_next = q_sat;
                    end
                    if (item.flags[FLAG_FIN])
                    begin
                        rfin_next = 1'b1;
                        lc_next   = fin_lc(lc_open);
                    end
                end
            end
            OP_RX_WINDOW:
            begin
                lc_next  = lc_open;
                ack_next = ack_open;
                if (item.flags[FLAG_RST])
                begin
                    rst_seen_next = 1'b1;
                    lc_next       = LC_RESET;
                end
                else
                begin
                    send_next = s_sat;
                    if (item.flags[FLAG_FIN])
                    begin
                        rfin_next = 1'b1;
                        lc_next   = fin_lc(lc_open);
                    end
                end
            end
            OP_APP_READ:
            begin
                if (rst_seen_reg)
                begin
                    result_next.status = ST_RESET;
                end
                else if (down_reg && (queued_reg == '0))
                begin
                    result_next.status = ST_SHUTDOWN;
                end
                else if (queued_reg != '0)
                begin
                    queued_next            = queued_reg - rd_bytes;
                    result_next.byte_count = 32'(rd_bytes);
                    consumed_next          = c_sat;
                    if (win_hit)
                    begin
                        result_next.emit   = EM_WU;
                        result_next.amount = 32'(c_sat);
                        recv_next          = r_sat;
                        consumed_next      = '0;
                    end
                end
                else if (rfin_reg)
                begin
                    result_next.status = ST_EOF;
                end
                else
                begin
                    result_next.status = ST_BLOCK;
                end
            end
            OP_APP_WRITE:
            begin
                if (lfin_reg)
                begin
                    result_next.status = ST_CLOSED;
                end
                else if (rst_seen_reg)
                begin
                    result_next.status = ST_RESET;
                end
                else if (down_reg)
                begin
                    result_next.status = ST_SHUTDOWN;
                end
                else if (item.length == 32'd0)
                begin
                    result_next.status = ST_OK;
                end
                else if (send_reg == '0)
                begin
                    result_next.status = ST_BLOCK;
                end
                else
                begin
                    send_next              = send_reg - wr_bytes;
                    result_next.byte_count = 32'(wr_bytes);
                    result_next.emit       = EM_DATA;
                    result_next.amount     = 32'(wr_bytes);
                end
            end
            OP_CLOSE:
            begin
                if (!lfin_reg)
                begin
                    lfin_next = 1'b1;
                    if (lc_reg == LC_ESTABLISHED)
                    begin
                        lc_next = LC_LOCAL_CLOSE;
                    end
                    else if (lc_reg == LC_REMOTE_CLOSE)
                    begin
                        lc_next = LC_CLOSED;
                    end
                    if (down_reg)
                    begin
                        result_next.status = ST_SHUTDOWN;
                    end
                    else
                    begin
                        result_next.emit = EM_FIN;
                    end
                end
            end
            OP_RESET:
            begin
                if (!rst_seen_reg)
                begin
                    rst_seen_next = 1'b1;
                    lc_next       = LC_RESET;
                    if (down_reg)
                    begin
                        result_next.status = ST_SHUTDOWN;
                    end
                    else
                    begin
                        result_next.emit = EM_RST;
                    end
                end
            end
            OP_SESSION_CLOSED:
            begin
                down_next = 1'b1;
            end
            OP_OPEN_SENT:
            begin
                if (lc_reg == LC_INIT)
                begin
                    lc_next = LC_SYN_SENT;
                end
            end
            default:
            begin
                lc_next = lc_reg;
            end
        endcase

        result_next.state           = lc_next;
        result_next.ack_pending     = ack_next;
        result_next.remote_finished = rfin_next;
    end

    // stream state, result payload and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg        <= LC_INIT;
            send_reg      <= CREDIT_RESET;
            recv_reg      <= CREDIT_RESET;
            queued_reg    <= '0;
            consumed_reg  <= '0;
            lfin_reg      <= 1'b0;
            rfin_reg      <= 1'b0;
            rst_seen_reg  <= 1'b0;
            down_reg      <= 1'b0;
            ack_reg       <= 1'b0;
            result_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                lc_reg       <= lc_next;
                send_reg     <= send_next;
                recv_reg     <= recv_next;
                queued_reg   <= queued_next;
                consumed_reg <= consumed_next;
                lfin_reg     <= lfin_next;
                rfin_reg     <= rfin_next;
                rst_seen_reg <= rst_seen_next;
                down_reg     <= down_next;
                ack_reg      <= ack_next;
                result_reg   <= result_next;
            end
            if (item_ready)
            begin
                out_valid_reg <= item_valid;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

### hw/rtl/mux_stream_state_and_credit.sv
// path: each request passes the request register, then the result register
// throughput: one request per cycle while out_ready is high
// a stalled result holds at most two requests
// reset: rst_n clears the lifecycle to init, loads both credits with the
// reset window, clears all counts and flags and empties both registers
module mux_stream_state_and_credit
    import mssc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           op,
    input  logic [31:0]          length,
    input  logic [3:0]           frame_flags,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           status,
    output logic [2:0]           stream_state,
    output logic [31:0]          byte_count,
    output logic [2:0]           emit_frame,
    output logic [31:0]          emit_amount,
    output logic                 ack_pending,
    output logic                 remote_finished,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic        item_valid;
    item_t       item;
    logic        item_ready;
    result_t     result;
    logic [31:0] credit_window;

    // configuration register
    mssc_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .credit_window (credit_window)
    );

    // request register
    mssc_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .length      (length),
        .frame_flags (frame_flags),
        .item_valid  (item_valid),
        .item        (item),
        .item_ready  (item_ready)
    );

    // stream state and result register
    mssc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .credit_window (credit_window),
        .item_valid    (item_valid),
        .item          (item),
        .item_ready    (item_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result        (result)
    );

    assign status          = result.status;
    assign stream_state    = result.state;
    assign byte_count      = result.byte_count;
    assign emit_frame      = result.emit;
    assign emit_amount     = result.amount;
    assign ack_pending     = result.ack_pending;
    assign remote_finished = result.remote_finished;

endmodule

### tb/mux_stream_state_and_credit_tb.sv
`timescale 1ns / 100ps

module mux_stream_state_and_credit_tb;
    import mssc_pkg::*;

    localparam int HOLD_CYCLES  = 60;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int PHASE_ITEMS  = 200;
    localparam int MAX_PRINTED  = 50;

    localparam logic [3:0] F_SYN = 4'b0001 << FLAG_SYN;
    localparam logic [3:0] F_ACK = 4'b0001 << FLAG_ACK;
    localparam logic [3:0] F_FIN = 4'b0001 << FLAG_FIN;
    localparam logic [3:0] F_RST = 4'b0001 << FLAG_RST;

    // one planned request, with an optional hand-written expectation
    typedef struct {
        op_t         code;
        logic [31:0] len;
        logic [3:0]  flags;
        bit          typed;
        result_t     want;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [2:0]           op;
    logic [31:0]          length;
    logic [3:0]           frame_flags;
    logic                 out_valid;
    logic                 out_ready;
    logic [2:0]           status;
    logic [2:0]           stream_state;
    logic [31:0]          byte_count;
    logic [2:0]           emit_frame;
    logic [31:0]          emit_amount;
    logic                 ack_pending;
    logic                 remote_finished;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    logic ready_wish;
    logic hold_outputs;
    assign out_ready = ready_wish && !hold_outputs;

    // stream predictor state
    logic [31:0] window_cfg;
    lc_t         stream_lc;
    logic [31:0] tx_credit;
    logic [31:0] rx_credit;
    logic [31:0] rx_queued;
    logic [31:0] rx_consumed;
    bit          fin_out;
    bit          fin_in;
    bit          reset_flag;
    bit          session_gone;
    bit          ack_due;

    result_t pending_results[$];
    row_t    opening_rows[$];
    int      error_count;
    int      results_checked;
    int      requests_sent;
    bit      tx_steady;

    mux_stream_state_and_credit dut (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                     results_checked, what, got, want);
        end
    endtask

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // peer syn opens, ack completes the handshake
    function automatic void apply_syn_ack(logic [3:0] fl);
        if (fl[FLAG_SYN] && stream_lc == LC_INIT)
        begin
            stream_lc = LC_SYN_RECV;
            ack_due   = 1'b1;
        end
        if (fl[FLAG_ACK] && (stream_lc == LC_SYN_SENT || stream_lc == LC_SYN_RECV))
            stream_lc = LC_ESTABLISHED;
    endfunction

    function automatic void apply_fin(logic [3:0] fl);
        if (fl[FLAG_FIN])
        begin
            fin_in = 1'b1;
            if (stream_lc == LC_ESTABLISHED || stream_lc == LC_SYN_RECV)
                stream_lc = LC_REMOTE_CLOSE;
            else if (stream_lc == LC_LOCAL_CLOSE)
                stream_lc = LC_CLOSED;
        end
    endfunction

    // advance the stream by one request and return its result
    function automatic result_t stream_next(op_t o, logic [31:0] len, logic [3:0] fl);
        result_t     r;
        logic [31:0] take;
        r = '0;
        r.status = ST_OK;
        r.emit   = EM_NONE;
        case (o)
            OP_RX_DATA:
            begin
                apply_syn_ack(fl);
                if (len > rx_credit)
                    r.status = ST_WINDOW;
                else
                begin
                    rx_credit = rx_credit - len;
                    rx_queued = sat_sum(rx_queued, len);
                    apply_fin(fl);
                end
            end
            OP_RX_WINDOW:
            begin
                apply_syn_ack(fl);
                if (fl[FLAG_RST])
                begin
                    reset_flag = 1'b1;
                    stream_lc  = LC_RESET;
                end
                else
                begin
                    tx_credit = sat_sum(tx_credit, len);
                    apply_fin(fl);
                end
            end
            OP_APP_READ:
            begin
                if (reset_flag)
                    r.status = ST_RESET;
                else if (session_gone && rx_queued == 0)
                    r.status = ST_SHUTDOWN;
                else if (rx_queued != 0)
                begin
                    take         = (len < rx_queued) ? len : rx_queued;
                    rx_queued    = rx_queued - take;
                    rx_consumed  = sat_sum(rx_consumed, take);
                    r.byte_count = take;
                    // hand credit back once half the window has been consumed
                    if (rx_consumed >= (window_cfg >> 1))
                    begin
                        r.emit      = EM_WU;
                        r.amount    = rx_consumed;
                        rx_credit   = sat_sum(rx_credit, rx_consumed);
                        rx_consumed = '0;
                    end
                end
                else if (fin_in)
                    r.status = ST_EOF;
                else
                    r.status = ST_BLOCK;
            end
            OP_APP_WRITE:
            begin
                if (fin_out)
                    r.status = ST_CLOSED;
                else if (reset_flag)
                    r.status = ST_RESET;
                else if (session_gone)
                    r.status = ST_SHUTDOWN;
                else if (len == 0)
                    r.status = ST_OK;
                else if (tx_credit == 0)
                    r.status = ST_BLOCK;
                else
                begin
                    take         = (len < tx_credit) ? len : tx_credit;
                    tx_credit    = tx_credit - take;
                    r.byte_count = take;
                    r.emit       = EM_DATA;
                    r.amount     = take;
                end
            end
            OP_CLOSE:
            begin
                if (!fin_out)
                begin
                    fin_out = 1'b1;
                    if (stream_lc == LC_ESTABLISHED)
                        stream_lc = LC_LOCAL_CLOSE;
                    else if (stream_lc == LC_REMOTE_CLOSE)
                        stream_lc = LC_CLOSED;
                    if (session_gone)
                        r.status = ST_SHUTDOWN;
                    else
                        r.emit = EM_FIN;
                end
            end
            OP_RESET:
            begin
                if (!reset_flag)
                begin
                    reset_flag = 1'b1;
                    stream_lc  = LC_RESET;
                    if (session_gone)
                        r.status = ST_SHUTDOWN;
                    else
                        r.emit = EM_RST;
                end
            end
            OP_SESSION_CLOSED:
                session_gone = 1'b1;
            default:
            begin
                if (stream_lc == LC_INIT)
                    stream_lc = LC_SYN_SENT;
            end
        endcase
        r.state           = stream_lc;
        r.ack_pending     = ack_due;
        r.remote_finished = fin_in;
        return r;
    endfunction

    function automatic row_t plan_row(op_t o, logic [31:0] len, logic [3:0] fl,
                                      bit typed = 1'b0, result_t want = '0);
        row_t row;
        row.code  = o;
        row.len   = len;
        row.flags = fl;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // present one request, wait for its acceptance, queue what it should produce
    task automatic offer_request(input op_t o, input logic [31:0] len, input logic [3:0] fl,
                                 input bit typed = 1'b0, input result_t typed_want = '0);
        int      gap;
        result_t predicted;
        if ($urandom_range(0, 99) < 4)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        op          <= o;
        length      <= len;
        frame_flags <= fl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = stream_next(o, len, fl);
        pending_results.push_back(typed ? typed_want : predicted);
        requests_sent++;
    endtask

    task automatic offer_row(input row_t row);
        offer_request(row.code, row.len, row.flags, row.typed, row.want);
    endtask

    // random request; in open mode the stream is never torn down
    task automatic offer_random_request(input bit teardown);
        int          pick;
        int          k;
        op_t         o;
        logic [31:0] len;
        logic [31:0] cap;
        logic [3:0]  fl;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, 9);
        fl   = 4'($urandom_range(0, 15));
        if (!teardown)
        begin
            if (pick < 35)
                o = OP_RX_DATA;
            else if (pick < 50)
                o = OP_RX_WINDOW;
            else if (pick < 78)
                o = OP_APP_READ;
            else if (pick < 95)
                o = OP_APP_WRITE;
            else
                o = OP_OPEN_SENT;
        end
        else
        begin
            if (pick < 25)
                o = OP_RX_DATA;
            else if (pick < 35)
                o = OP_RX_WINDOW;
            else if (pick < 60)
                o = OP_APP_READ;
            else if (pick < 80)
                o = OP_APP_WRITE;
            else if (pick < 85)
                o = OP_CLOSE;
            else if (pick < 90)
                o = OP_RESET;
            else if (pick < 95)
                o = OP_SESSION_CLOSED;
            else
                o = OP_OPEN_SENT;
        end
        case (o)
            OP_RX_DATA:
            begin
                cap = (rx_credit < 4096) ? rx_credit : 32'd4096;
                if (k == 0)
                    len = '0;
                else if (k == 1)
                    len = $urandom;
                else if (k == 2)
                    len = rx_credit;
                else
                    len = $urandom_range(0, cap);
                if (!teardown)
                    fl[FLAG_FIN] = 1'b0;
            end
            OP_RX_WINDOW:
            begin
                len = (k < 2) ? $urandom : $urandom_range(0, 8192);
                if (!teardown)
                begin
                    fl[FLAG_FIN] = 1'b0;
                    fl[FLAG_RST] = 1'b0;
                end
            end
            OP_APP_READ:
                len = (k == 0) ? $urandom : (k == 1) ? 32'd0 : $urandom_range(1, 4096);
            OP_APP_WRITE:
                len = (k == 0) ? $urandom : (k == 1) ? 32'd0 : $urandom_range(1, 8192);
            default:
                len = $urandom;
        endcase
        offer_request(o, len, fl);
    endtask

    task automatic load_opening_rows();
        opening_rows.push_back(plan_row(OP_APP_READ, 32'd10, 4'h0, 1'b1,
            result_t'{ST_BLOCK, LC_INIT, 32'd0, EM_NONE, 32'd0, 1'b0, 1'b0}));
        opening_rows.push_back(plan_row(OP_APP_WRITE, 32'd0, 4'h0, 1'b1,
            result_t'{ST_OK, LC_INIT, 32'd0, EM_NONE, 32'd0, 1'b0, 1'b0}));
        opening_rows.push_back(plan_row(OP_RX_WINDOW, 32'd0, 4'h0, 1'b1,
            result_t'{ST_OK, LC_INIT, 32'd0, EM_NONE, 32'd0, 1'b0, 1'b0}));
        opening_rows.push_back(plan_row(OP_RX_DATA, 32'd300000, 4'h0, 1'b1,
            result_t'{ST_WINDOW, LC_INIT, 32'd0, EM_NONE, 32'd0, 1'b0, 1'b0}));
        // open from this side or from the peer, the other one is left to another seed
        if ($urandom_range(0, 1))
            opening_rows.push_back(plan_row(OP_OPEN_SENT, 32'd0, 4'h0));
        else
            opening_rows.push_back(plan_row(OP_RX_DATA, 32'd0, F_SYN));
        opening_rows.push_back(plan_row(OP_OPEN_SENT, 32'hFFFF_FFFF, 4'hF));
        opening_rows.push_back(plan_row(OP_RX_DATA, 32'd0, F_ACK));
        opening_rows.push_back(plan_row(OP_RX_DATA, 32'd300000, 4'h0));
        // rst on a data frame is ignored
        opening_rows.push_back(plan_row(OP_RX_DATA, 32'd100, F_RST));
        opening_rows.push_back(plan_row(OP_APP_READ, 32'hFFFF_FFFF, 4'h0));
        opening_rows.push_back(plan_row(OP_APP_WRITE, 32'hFFFF_FFFF, 4'h0));
        opening_rows.push_back(plan_row(OP_APP_WRITE, 32'd5, 4'h0));
        // send credit saturates
        opening_rows.push_back(plan_row(OP_RX_WINDOW, 32'hFFFF_FFFF, 4'h0));
        opening_rows.push_back(plan_row(OP_RX_WINDOW, 32'hFFFF_FFFF, 4'h0));
        opening_rows.push_back(plan_row(OP_APP_WRITE, 32'hFFFF_FFFF, 4'h0));
        opening_rows.push_back(plan_row(OP_RX_DATA, 32'd131072, F_SYN | F_ACK));
        opening_rows.push_back(plan_row(OP_APP_READ, 32'd200000, 4'h0));
        opening_rows.push_back(plan_row(OP_APP_READ, 32'd1, 4'h0));
        opening_rows.push_back(plan_row(OP_RX_DATA, 32'hFFFF_FFFF, 4'h0));
        opening_rows.push_back(plan_row(OP_RX_DATA, 32'd262144, 4'h0));
        opening_rows.push_back(plan_row(OP_RX_DATA, 32'd1, 4'h0));
        opening_rows.push_back(plan_row(OP_RX_DATA, 32'd0, 4'h0));
        opening_rows.push_back(plan_row(OP_APP_READ, 32'd262144, 4'h0));
    endtask

    // fin, close, reset and session loss in a random order, each followed by a read and write
    task automatic run_teardown_script();
        row_t        finale[$];
        row_t        tmp;
        int          j;
        logic [31:0] rd_len;
        finale.push_back(plan_row(OP_RX_DATA, $urandom_range(0, 64), F_FIN));
        finale.push_back(plan_row(OP_RX_DATA, 32'd0, F_FIN | F_RST));
        finale.push_back(plan_row(OP_CLOSE, 32'd0, 4'h0));
        finale.push_back(plan_row(OP_CLOSE, 32'd0, 4'h0));
        finale.push_back(plan_row(OP_SESSION_CLOSED, 32'd0, 4'h0));
        finale.push_back(plan_row(OP_RESET, 32'd0, 4'h0));
        finale.push_back(plan_row(OP_RESET, 32'd0, 4'h0));
        finale.push_back(plan_row(OP_RX_WINDOW, 32'd10, F_RST));
        for (int i = finale.size() - 1; i > 0; i--)
        begin
            j         = $urandom_range(0, i);
            tmp       = finale[i];
            finale[i] = finale[j];
            finale[j] = tmp;
        end
        foreach (finale[i])
        begin
            offer_row(finale[i]);
            rd_len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(0, 200);
            offer_request(OP_APP_READ, rd_len, 4'h0);
            offer_request(OP_APP_WRITE, $urandom_range(0, 200), 4'h0);
        end
    endtask

    // stop offering and let every expected result come back
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WINDOW;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        window_cfg = value;
    endtask

    task automatic check_window_readback();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WINDOW;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== window_cfg)
            report_mismatch("window register readback", prdata, window_cfg);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status_t'(status), lc_t'(stream_state), byte_count,
                    emit_t'(emit_frame), emit_amount, ack_pending, remote_finished};
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", 32'd1, 32'd0);
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.state !== want.state)
                    report_mismatch("stream_state", 32'(got.state), 32'(want.state));
                if (got.byte_count !== want.byte_count)
                    report_mismatch("byte_count", got.byte_count, want.byte_count);
                if (got.emit !== want.emit)
                    report_mismatch("emit_frame", 32'(got.emit), 32'(want.emit));
                if (got.amount !== want.amount)
                    report_mismatch("emit_amount", got.amount, want.amount);
                if (got.ack_pending !== want.ack_pending)
                    report_mismatch("ack_pending", 32'(got.ack_pending),
                                    32'(want.ack_pending));
                if (got.remote_finished !== want.remote_finished)
                    report_mismatch("remote_finished", 32'(got.remote_finished),
                                    32'(want.remote_finished));
            end
            results_checked++;
        end
    end

    // result side: random stalls with steady stretches
    initial
    begin
        int gap;
        bit rx_steady;
        ready_wish = 1'b0;
        rx_steady  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 99) < 4)
                rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 8);
            @(negedge clk);
            if (gap > 0)
            begin
                ready_wish <= 1'b0;
                repeat (gap)
                    @(negedge clk);
            end
            ready_wish <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // long result-side hold so the block fills and backs up its input
    initial
    begin
        hold_outputs = 1'b0;
        for (int k = 0; k < 2; k++)
        begin
            wait (requests_sent >= ((k == 0) ? 250 : 900));
            @(negedge clk);
            hold_outputs <= 1'b1;
            repeat (HOLD_CYCLES)
                @(negedge clk);
            hold_outputs <= 1'b0;
        end
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // main sequence
    initial
    begin
        logic [31:0] windows[6];
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_RX_DATA;
        length       = '0;
        frame_flags  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        window_cfg   = WINDOW_RESET;
        stream_lc    = LC_INIT;
        tx_credit    = WINDOW_RESET;
        rx_credit    = WINDOW_RESET;
        rx_queued    = '0;
        rx_consumed  = '0;
        fin_out      = 1'b0;
        fin_in       = 1'b0;
        reset_flag   = 1'b0;
        session_gone = 1'b0;
        ack_due      = 1'b0;
        tx_steady    = 1'b0;

        windows[0] = 32'd2;
        windows[1] = 32'hFFFF_FFFF;
        windows[2] = $urandom_range(2, 4096);
        windows[3] = $urandom;
        if (windows[3] < 2)
            windows[3] = 32'd2;
        windows[4] = 32'd3;
        windows[5] = WINDOW_RESET;

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_window_readback();

        load_opening_rows();
        foreach (opening_rows[i])
            offer_row(opening_rows[i]);
        repeat (PHASE_ITEMS)
            offer_random_request(1'b0);

        // each window setting gets its own phase, the last one tears the stream down
        foreach (windows[p])
        begin
            wait_for_results();
            write_window(windows[p]);
            check_window_readback();
            if (p < 5)
            begin
                repeat (PHASE_ITEMS)
                    offer_random_request(1'b0);
            end
            else
            begin
                run_teardown_script();
                repeat (150)
                    offer_random_request(1'b1);
            end
        end

        wait_for_results();
        repeat (4)
            @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mssc_pkg.sv
hw/rtl/mssc_cfg.sv
hw/rtl/mssc_in_stage.sv
hw/rtl/mssc_core.sv
hw/rtl/mux_stream_state_and_credit.sv
tb/mux_stream_state_and_credit_tb.sv
